// ===== rtl/smm_pkg.sv =====
// shared types and constants of the square matrix multiplier
package smm_pkg;

  // fixed field widths of the input and result words
  localparam int unsigned SizeW   = 3;
  localparam int unsigned RowW    = 2;
  localparam int unsigned ColW    = 2;
  localparam int unsigned InElemW = 16;
  localparam int unsigned ValueW  = 34;

  localparam logic [SizeW-1:0] SizeReset = 3'd4;

  // bookkeeping that travels with one read pair through the datapath
  typedef struct packed {
    logic            first;     // first term of a dot product
    logic            last;      // last term of a dot product
    logic            run_last;  // final element of the product matrix
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
  } tag_t;

  // one read pair issued by the sequencer
  typedef struct packed {
    logic valid;
    tag_t tag;
  } issue_t;

  // datapath occupancy seen by the sequencer
  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } mac_status_t;

endpackage

// ===== rtl/square_matrix_multiply.sv =====
// top level of the square matrix multiplier
// Multiplies two square matrices of size 2 to MAX_DIM (set by cfg_data_i, reset 4) held
// in two rams. Each input word writes one Q8.8 element of A or B; a word with
// compute_now_i set then emits the n*n elements of A*B in row-major order as Q18.16, the
// last one marked. Each product element takes one read pair of A and B
// per cycle through the single multiply-accumulate unit, then read, multiply and
// accumulate stages, and a new element starts once the output word is taken. During a
// full run in_stall_o is high. A new input word is taken while the final result still
// waits. Elements never written read as garbage.
module square_matrix_multiply #(
  parameter int unsigned MAX_DIM   = 4,
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [smm_pkg::SizeW-1:0]          cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               which_matrix_i,
  input  logic [smm_pkg::RowW-1:0]           row_i,
  input  logic [smm_pkg::ColW-1:0]           column_i,
  input  logic signed [smm_pkg::InElemW-1:0] element_value_i,
  input  logic                               compute_now_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [smm_pkg::RowW-1:0]           out_row_o,
  output logic [smm_pkg::ColW-1:0]           out_column_o,
  output logic signed [smm_pkg::ValueW-1:0]  product_value_o,
  output logic                               last_of_run_o
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AddrW = $clog2(Depth);

  logic [smm_pkg::SizeW-1:0] size_q;
  logic                      in_accept;
  logic                      in_range;
  logic [AddrW-1:0]          waddr;
  logic [ELEM_BITS-1:0]      wdata;
  logic                      busy;
  smm_pkg::issue_t           issue;
  smm_pkg::mac_status_t      mac_status;
  logic [AddrW-1:0]          addr_a, addr_b;
  logic [ELEM_BITS-1:0]      a_data, b_data;

  // size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= smm_pkg::SizeReset;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  // element write; indexes beyond the store are dropped
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(row_i) < 32'(MAX_DIM)) && (32'(column_i) < 32'(MAX_DIM));
  assign waddr      = AddrW'(32'(row_i) * MAX_DIM + 32'(column_i));
  assign wdata      = ELEM_BITS'(element_value_i);

  smm_ram #(
    .Width (ELEM_BITS),
    .Depth (Depth)
  ) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && in_range && !which_matrix_i),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue.valid),
    .raddr_i (addr_a),
    .rdata_o (a_data)
  );

  smm_ram #(
    .Width (ELEM_BITS),
    .Depth (Depth)
  ) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && in_range && which_matrix_i),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (issue.valid),
    .raddr_i (addr_b),
    .rdata_o (b_data)
  );

  // read sequencer
  smm_seq #(
    .MAX_DIM (MAX_DIM)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (in_accept && compute_now_i),
    .size_i       (size_q),
    .mac_status_i (mac_status),
    .busy_o       (busy),
    .issue_o      (issue),
    .addr_a_o     (addr_a),
    .addr_b_o     (addr_b)
  );

  // multiply-accumulate and output word
  smm_mac #(
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .issue_i         (issue),
    .a_i             (a_data),
    .b_i             (b_data),
    .out_stall_i     (out_stall_i),
    .status_o        (mac_status),
    .out_valid_o     (out_valid_o),
    .out_row_o       (out_row_o),
    .out_column_o    (out_column_o),
    .product_value_o (product_value_o),
    .last_of_run_o   (last_of_run_o)
  );

  // reads happen only while input is held off, so no write can race them
  a_read_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue.valid |-> in_stall_o)
    else $error("ram read issued while input words are accepted");

  // a dot product starts only into an empty datapath and output word
  a_start_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue.valid && issue.tag.first) |-> (!mac_status.pipe_busy && !mac_status.out_full))
    else $error("dot product started before previous result cleared");

  // the final element of a run sits on the diagonal
  a_last_on_diag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_of_run_o) |-> (out_row_o == out_column_o))
    else $error("last result word off the diagonal");

endmodule

// ===== rtl/smm_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
module smm_ram #(
  parameter  int unsigned Width = 16,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/smm_seq.sv =====
// sequencer: walks rows, columns and dot-product terms and issues ram reads
module smm_seq #(
  parameter  int unsigned MAX_DIM = 4,
  localparam int unsigned DimW    = $clog2(MAX_DIM),
  localparam int unsigned AddrW   = $clog2(MAX_DIM * MAX_DIM)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [smm_pkg::SizeW-1:0]  size_i,
  input  smm_pkg::mac_status_t       mac_status_i,
  output logic                       busy_o,
  output smm_pkg::issue_t            issue_o,
  output logic [AddrW-1:0]           addr_a_o,
  output logic [AddrW-1:0]           addr_b_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StWait  = 2'd1;
  localparam logic [1:0] StIssue = 2'd2;

  logic [1:0]      state_q, state_d;
  logic [DimW-1:0] i_q, i_d;
  logic [DimW-1:0] j_q, j_d;
  logic [DimW-1:0] k_q, k_d;
  logic [DimW-1:0] last_idx;

  // active size clamped to the range two to MAX_DIM, as a last index
  always_comb begin
    if (size_i < 3'd2) begin
      last_idx = DimW'(1);
    end else if (32'(size_i) > 32'(MAX_DIM)) begin
      last_idx = DimW'(MAX_DIM - 1);
    end else begin
      last_idx = DimW'(size_i - 3'd1);
    end
  end

  // control: one dot product at a time, next one once the datapath has drained and the output word is taken
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StWait;
          i_d     = '0;
          j_d     = '0;
        end
      end
      StWait: begin
        if (!mac_status_i.pipe_busy && !mac_status_i.out_full) begin
          state_d = StIssue;
          k_d     = '0;
        end
      end
      StIssue: begin
        if (k_q == last_idx) begin
          state_d = StWait;
          if (j_q == last_idx) begin
            j_d = '0;
            if (i_q == last_idx) begin
              state_d = StIdle;
            end else begin
              i_d = i_q + DimW'(1);
            end
          end else begin
            j_d = j_q + DimW'(1);
          end
        end else begin
          k_d = k_q + DimW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  // read pair for A[i][k] and B[k][j]
  always_comb begin
    issue_o.valid        = (state_q == StIssue);
    issue_o.tag.first    = (k_q == '0);
    issue_o.tag.last     = (k_q == last_idx);
    issue_o.tag.run_last = (i_q == last_idx) && (j_q == last_idx);
    issue_o.tag.row      = smm_pkg::RowW'(i_q);
    issue_o.tag.col      = smm_pkg::ColW'(j_q);
  end

  assign addr_a_o = AddrW'(i_q * MAX_DIM + k_q);
  assign addr_b_o = AddrW'(k_q * MAX_DIM + j_q);
  assign busy_o   = (state_q != StIdle);

endmodule

// ===== rtl/smm_mac.sv =====
// multiply-accumulate datapath and result output register
module smm_mac #(
  parameter int unsigned ELEM_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  smm_pkg::issue_t                    issue_i,
  input  logic [ELEM_BITS-1:0]               a_i,
  input  logic [ELEM_BITS-1:0]               b_i,
  input  logic                               out_stall_i,
  output smm_pkg::mac_status_t               status_o,
  output logic                               out_valid_o,
  output logic [smm_pkg::RowW-1:0]           out_row_o,
  output logic [smm_pkg::ColW-1:0]           out_column_o,
  output logic signed [smm_pkg::ValueW-1:0]  product_value_o,
  output logic                               last_of_run_o
);

  localparam int unsigned ProdW = 2 * ELEM_BITS;

  logic                               v1_q, v2_q;
  smm_pkg::tag_t                      tag1_q, tag2_q;
  logic signed [ProdW-1:0]            prod_d, prod_q;
  logic signed [smm_pkg::ValueW-1:0]  term, sum_d, acc_q;
  logic                               load;
  logic                               out_valid_q, out_valid_d;
  logic [smm_pkg::RowW-1:0]           out_row_q;
  logic [smm_pkg::ColW-1:0]           out_col_q;
  logic signed [smm_pkg::ValueW-1:0]  out_value_q;
  logic                               out_last_q;

  // multiply the registered ram words
  assign prod_d = $signed(a_i) * $signed(b_i);

  // accumulate; the sum wraps at the result width
  assign term  = smm_pkg::ValueW'(prod_q);
  assign sum_d = tag2_q.first ? term : acc_q + term;
  assign load  = v2_q && tag2_q.last;

  // output word is held until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= issue_i.valid;
      v2_q        <= v1_q;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath payload
  always_ff @(posedge clk_i) begin
    tag1_q <= issue_i.tag;
    tag2_q <= tag1_q;
    if (v1_q) begin
      prod_q <= prod_d;
    end
    if (v2_q) begin
      acc_q <= sum_d;
    end
    if (load) begin
      out_value_q <= sum_d;
      out_row_q   <= tag2_q.row;
      out_col_q   <= tag2_q.col;
      out_last_q  <= tag2_q.run_last;
    end
  end

  assign status_o.pipe_busy = v1_q || v2_q;
  assign status_o.out_full  = out_valid_q;

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = out_row_q;
  assign out_column_o    = out_col_q;
  assign product_value_o = out_value_q;
  assign last_of_run_o   = out_last_q;

endmodule
